// ===== rtl/qsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qsl_pkg
// Shared constants, types and the microprogram of the quicksort sorter.
// ---------------------------------------------------------------------------
package qsl_pkg;

  localparam int MaxElems   = 64;
  localparam int StoreDepth = 64;
  localparam int StackDepth = 64;
  localparam int DataW      = 32;
  localparam int AddrW      = 6;
  localparam int CountW     = 7;
  localparam int RangeW     = 2 * AddrW;
  localparam int PcW        = 4;

  localparam logic [CountW-1:0] MaxElemsC   = CountW'(MaxElems);
  localparam logic [CountW-1:0] StackDepthC = CountW'(StackDepth);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_RANGE,
    OP_PIVOT,
    OP_SCAN,
    OP_TEST,
    OP_SWAPA,
    OP_SWAPB,
    OP_FIN,
    OP_FINA,
    OP_FINB,
    OP_PUSHL,
    OP_EMIT0,
    OP_EMIT
  } ucode_op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IN_MORE,
    COND_SMALL_SET,
    COND_STACK_EMPTY,
    COND_RANGE_EMPTY,
    COND_J_AT_HI,
    COND_NOT_LESS,
    COND_MORE_EMIT
  } jump_cond_t;

  typedef struct packed {
    ucode_op_t        op;
    hold_t            hold;
    jump_cond_t       cond;
    logic [PcW-1:0]   target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_idle;
    logic out_busy;
    logic in_more;
    logic small_set;
    logic stack_empty;
    logic range_empty;
    logic j_at_hi;
    logic not_less;
    logic more_emit;
  } dp_status_t;

  typedef struct packed {
    logic             load;
    logic [DataW-1:0] value;
    logic             end_of_set;
    logic             overflow;
  } emit_t;

  // program step addresses
  localparam logic [PcW-1:0] PcLoad  = PcW'(0);
  localparam logic [PcW-1:0] PcPop   = PcW'(2);
  localparam logic [PcW-1:0] PcScan  = PcW'(5);
  localparam logic [PcW-1:0] PcFin   = PcW'(9);
  localparam logic [PcW-1:0] PcEmit0 = PcW'(13);
  localparam logic [PcW-1:0] PcERead = PcW'(14);

  function automatic ctrl_word_t ucode(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, hold: HOLD_NONE, cond: COND_NEVER, target: PcLoad};
    unique case (pc)
      PcW'(0):  w = '{op: OP_LOAD,  hold: HOLD_IN,   cond: COND_IN_MORE,     target: PcLoad};
      PcW'(1):  w = '{op: OP_INIT,  hold: HOLD_NONE, cond: COND_SMALL_SET,   target: PcEmit0};
      PcW'(2):  w = '{op: OP_POP,   hold: HOLD_NONE, cond: COND_STACK_EMPTY, target: PcEmit0};
      PcW'(3):  w = '{op: OP_RANGE, hold: HOLD_NONE, cond: COND_RANGE_EMPTY, target: PcPop};
      PcW'(4):  w = '{op: OP_PIVOT, hold: HOLD_NONE, cond: COND_NEVER,       target: PcLoad};
      PcW'(5):  w = '{op: OP_SCAN,  hold: HOLD_NONE, cond: COND_J_AT_HI,     target: PcFin};
      PcW'(6):  w = '{op: OP_TEST,  hold: HOLD_NONE, cond: COND_NOT_LESS,    target: PcScan};
      PcW'(7):  w = '{op: OP_SWAPA, hold: HOLD_NONE, cond: COND_NEVER,       target: PcLoad};
      PcW'(8):  w = '{op: OP_SWAPB, hold: HOLD_NONE, cond: COND_ALWAYS,      target: PcScan};
      PcW'(9):  w = '{op: OP_FIN,   hold: HOLD_NONE, cond: COND_NEVER,       target: PcLoad};
      PcW'(10): w = '{op: OP_FINA,  hold: HOLD_NONE, cond: COND_NEVER,       target: PcLoad};
      PcW'(11): w = '{op: OP_FINB,  hold: HOLD_NONE, cond: COND_NEVER,       target: PcLoad};
      PcW'(12): w = '{op: OP_PUSHL, hold: HOLD_NONE, cond: COND_ALWAYS,      target: PcPop};
      PcW'(13): w = '{op: OP_EMIT0, hold: HOLD_NONE, cond: COND_NEVER,       target: PcLoad};
      PcW'(14): w = '{op: OP_NOP,   hold: HOLD_OUT,  cond: COND_NEVER,       target: PcLoad};
      PcW'(15): w = '{op: OP_EMIT,  hold: HOLD_NONE, cond: COND_MORE_EMIT,   target: PcERead};
      default:  w = '{op: OP_NOP,   hold: HOLD_NONE, cond: COND_ALWAYS,      target: PcLoad};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/quicksort_lomuto_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quicksort_lomuto_sorter
// Collects a set of signed words, sorts it by quicksort with Lomuto
// partitioning and a range stack, then streams it out in ascending order.
//
//   channel  signals                        beat
//   in       in_valid in_stall              value, is_last
//   out      out_valid out_stall            sorted_value, end_of_set, overflow
//
// loading takes one cycle per beat; beats beyond 64 are dropped and flagged
// sorting: per range, the last element becomes the pivot, and each element below it is
//   swapped forward, all through the one read and one write port of the element RAM
// output beats are read from the element RAM and wait while the out channel is stalled
// rst clears the sequencer, stack pointer, count, overflow flag and output valid
// in_stall is high from the last input beat of a set until its last output beat is loaded
// ---------------------------------------------------------------------------
module quicksort_lomuto_sorter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [qsl_pkg::DataW-1:0] value,
  input  wire logic                      is_last,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [qsl_pkg::DataW-1:0] sorted_value,
  output logic                           end_of_set,
  output logic                           overflow
);

  qsl_pkg::ucode_op_t  op;
  qsl_pkg::dp_status_t status;
  qsl_pkg::emit_t      emit;
  logic                in_fire;
  logic                out_busy;

  assign in_stall = op != qsl_pkg::OP_LOAD;
  assign in_fire  = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;

  qsl_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  qsl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .in_fire  (in_fire),
    .out_busy (out_busy),
    .value    (value),
    .is_last  (is_last),
    .status   (status),
    .emit     (emit)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      sorted_value <= emit.value;
      end_of_set   <= emit.end_of_set;
      overflow     <= emit.overflow;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qsl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qsl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module qsl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/qsl_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qsl_sequencer
// Step counter over the microprogram ROM with hold and conditional jumps.
// ---------------------------------------------------------------------------
module qsl_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qsl_pkg::dp_status_t status,
  output qsl_pkg::ucode_op_t      op
);

  logic [qsl_pkg::PcW-1:0] pc;
  logic [qsl_pkg::PcW-1:0] pc_next;
  qsl_pkg::ctrl_word_t     word;
  logic                    hold;
  logic                    jump;

  assign word = qsl_pkg::ucode(pc);
  assign op   = word.op;

  always_comb begin
    unique case (word.hold)
      qsl_pkg::HOLD_IN:  hold = status.in_idle;
      qsl_pkg::HOLD_OUT: hold = status.out_busy;
      default:           hold = 1'b0;
    endcase
    unique case (word.cond)
      qsl_pkg::COND_ALWAYS:      jump = 1'b1;
      qsl_pkg::COND_IN_MORE:     jump = status.in_more;
      qsl_pkg::COND_SMALL_SET:   jump = status.small_set;
      qsl_pkg::COND_STACK_EMPTY: jump = status.stack_empty;
      qsl_pkg::COND_RANGE_EMPTY: jump = status.range_empty;
      qsl_pkg::COND_J_AT_HI:     jump = status.j_at_hi;
      qsl_pkg::COND_NOT_LESS:    jump = status.not_less;
      qsl_pkg::COND_MORE_EMIT:   jump = status.more_emit;
      default:                   jump = 1'b0;
    endcase
    priority if (hold) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= qsl_pkg::PcLoad;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qsl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qsl_datapath
// Element store, range stack and index registers driven by the microprogram.
// ---------------------------------------------------------------------------
module qsl_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire qsl_pkg::ucode_op_t         op,
  input  wire logic                       in_fire,
  input  wire logic                       out_busy,
  input  wire logic [qsl_pkg::DataW-1:0]  value,
  input  wire logic                       is_last,
  output qsl_pkg::dp_status_t             status,
  output qsl_pkg::emit_t                  emit
);

  logic [qsl_pkg::AddrW-1:0]  lo;
  logic [qsl_pkg::AddrW-1:0]  hi;
  logic [qsl_pkg::AddrW-1:0]  j;
  logic [qsl_pkg::AddrW-1:0]  nxt;
  logic [qsl_pkg::AddrW-1:0]  k;
  logic [qsl_pkg::DataW-1:0]  pivot;
  logic [qsl_pkg::DataW-1:0]  a;
  logic [qsl_pkg::CountW-1:0] sp;
  logic [qsl_pkg::CountW-1:0] count;
  logic                       ovf;

  logic                       st_we;
  logic [qsl_pkg::AddrW-1:0]  st_waddr;
  logic [qsl_pkg::DataW-1:0]  st_wdata;
  logic [qsl_pkg::AddrW-1:0]  st_raddr;
  logic [qsl_pkg::DataW-1:0]  st_q;

  logic                       sk_we;
  logic [qsl_pkg::AddrW-1:0]  sk_waddr;
  logic [qsl_pkg::RangeW-1:0] sk_wdata;
  logic [qsl_pkg::AddrW-1:0]  sk_raddr;
  logic [qsl_pkg::RangeW-1:0] sk_q;

  logic                       room;
  logic                       less;
  logic                       last_emit;
  logic [qsl_pkg::CountW-1:0] nxt_inc;
  logic [qsl_pkg::CountW-1:0] lo_inc;
  logic [qsl_pkg::CountW-1:0] k_inc;
  logic [qsl_pkg::CountW-1:0] sp_dec;
  logic                       push_ok;
  logic                       push_req;

  assign room      = count < qsl_pkg::MaxElemsC;
  assign less      = $signed(st_q) < $signed(pivot);
  assign nxt_inc   = {1'b0, nxt} + 1'b1;
  assign lo_inc    = {1'b0, lo} + 1'b1;
  assign k_inc     = {1'b0, k} + 1'b1;
  assign sp_dec    = sp - 1'b1;
  assign last_emit = k_inc == count;
  assign push_ok   = sp < qsl_pkg::StackDepthC;

  assign status.in_idle     = !in_fire;
  assign status.out_busy    = out_busy;
  assign status.in_more     = in_fire && !is_last;
  assign status.small_set   = count < qsl_pkg::CountW'(2);
  assign status.stack_empty = sp == '0;
  assign status.range_empty = sk_q[qsl_pkg::AddrW-1:0] <= sk_q[qsl_pkg::RangeW-1:qsl_pkg::AddrW];
  assign status.j_at_hi     = j == hi;
  assign status.not_less    = !less;
  assign status.more_emit   = !last_emit;

  assign emit.load       = op == qsl_pkg::OP_EMIT;
  assign emit.value      = st_q;
  assign emit.end_of_set = last_emit;
  assign emit.overflow   = ovf;

  // element store ports
  always_comb begin
    st_we    = 1'b0;
    st_waddr = j;
    st_wdata = st_q;
    st_raddr = j;
    unique case (op)
      qsl_pkg::OP_LOAD: begin
        st_we    = in_fire && room;
        st_waddr = count[qsl_pkg::AddrW-1:0];
        st_wdata = value;
      end
      qsl_pkg::OP_RANGE: st_raddr = sk_q[qsl_pkg::AddrW-1:0];
      qsl_pkg::OP_TEST:  st_raddr = nxt;
      qsl_pkg::OP_SWAPA: begin
        st_we = 1'b1;
      end
      qsl_pkg::OP_SWAPB: begin
        st_we    = 1'b1;
        st_waddr = nxt;
        st_wdata = a;
      end
      qsl_pkg::OP_FIN:   st_raddr = nxt;
      qsl_pkg::OP_FINA: begin
        st_we    = 1'b1;
        st_waddr = hi;
      end
      qsl_pkg::OP_FINB: begin
        st_we    = 1'b1;
        st_waddr = nxt;
        st_wdata = pivot;
      end
      qsl_pkg::OP_EMIT0, qsl_pkg::OP_EMIT, qsl_pkg::OP_NOP: st_raddr = k;
      default: st_raddr = j;
    endcase
  end

  // range stack ports
  always_comb begin
    push_req = 1'b0;
    sk_wdata = {lo, hi};
    sk_raddr = sp_dec[qsl_pkg::AddrW-1:0];
    unique case (op)
      qsl_pkg::OP_INIT: begin
        push_req = !status.small_set;
        sk_wdata = {qsl_pkg::AddrW'(0), sp_dec[qsl_pkg::AddrW-1:0] ^ sp_dec[qsl_pkg::AddrW-1:0]
                    ^ count[qsl_pkg::AddrW-1:0] - 1'b1};
      end
      qsl_pkg::OP_FINB: begin
        push_req = nxt_inc < {1'b0, hi};
        sk_wdata = {nxt_inc[qsl_pkg::AddrW-1:0], hi};
      end
      qsl_pkg::OP_PUSHL: begin
        push_req = {1'b0, nxt} > lo_inc;
        sk_wdata = {lo, nxt - 1'b1};
      end
      default: push_req = 1'b0;
    endcase
    sk_we    = push_req && push_ok;
    sk_waddr = sp[qsl_pkg::AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp    <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (op)
        qsl_pkg::OP_LOAD: begin
          if (in_fire) begin
            if (room) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        qsl_pkg::OP_INIT: begin
          sp <= sk_we ? qsl_pkg::CountW'(1) : '0;
        end
        qsl_pkg::OP_POP: begin
          if (!status.stack_empty) begin
            sp <= sp_dec;
          end
        end
        qsl_pkg::OP_FINB, qsl_pkg::OP_PUSHL: begin
          if (sk_we) begin
            sp <= sp + 1'b1;
          end
        end
        qsl_pkg::OP_EMIT: begin
          if (last_emit) begin
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: sp <= sp;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      qsl_pkg::OP_RANGE: begin
        lo  <= sk_q[qsl_pkg::RangeW-1:qsl_pkg::AddrW];
        hi  <= sk_q[qsl_pkg::AddrW-1:0];
        j   <= sk_q[qsl_pkg::RangeW-1:qsl_pkg::AddrW];
        nxt <= sk_q[qsl_pkg::RangeW-1:qsl_pkg::AddrW];
      end
      qsl_pkg::OP_PIVOT: pivot <= st_q;
      qsl_pkg::OP_TEST: begin
        a <= st_q;
        if (!less) begin
          j <= j + 1'b1;
        end
      end
      qsl_pkg::OP_SWAPB: begin
        nxt <= nxt + 1'b1;
        j   <= j + 1'b1;
      end
      qsl_pkg::OP_EMIT0: k <= '0;
      qsl_pkg::OP_EMIT:  k <= k_inc[qsl_pkg::AddrW-1:0];
      default: a <= a;
    endcase
  end

  qsl_ram #(
    .Width (qsl_pkg::DataW),
    .Depth (qsl_pkg::StoreDepth)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_q)
  );

  qsl_ram #(
    .Width (qsl_pkg::RangeW),
    .Depth (qsl_pkg::StackDepth)
  ) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_q)
  );

endmodule
`default_nettype wire
